// ----- src/cgdc_pkg.sv -----
// Package for the color guided drive controller: item types, codes and constants.
package cgdc_pkg;

    localparam int CNT_W  = 16;
    localparam int PCT_W  = CNT_W + 7;
    localparam int TIME_W = 32;
    localparam int DUTY_W = 13;
    localparam int SHARE_W = 7;
    localparam int STEP_W = $clog2(PCT_W);
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(100);
    localparam logic [PCT_W:0]   PCT_MARGIN = (PCT_W + 1)'(8);

    localparam logic [7:0] CMD_STOP    = 8'h73;
    localparam logic [7:0] CMD_ENABLE  = 8'h65;
    localparam logic [7:0] CMD_FORWARD = 8'h66;
    localparam logic [7:0] CMD_LEFT    = 8'h6c;
    localparam logic [7:0] CMD_RIGHT   = 8'h72;

    localparam logic [1:0] CLS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLS_RED     = 2'd1;
    localparam logic [1:0] CLS_GREEN   = 2'd2;
    localparam logic [1:0] CLS_BLUE    = 2'd3;

    localparam logic [1:0] OVR_NONE  = 2'd0;
    localparam logic [1:0] OVR_RED   = 2'd1;
    localparam logic [1:0] OVR_PAUSE = 2'd2;
    localparam logic [1:0] OVR_TURN  = 2'd3;

    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_FORWARD = 2'd1;
    localparam logic [1:0] DRV_LEFT    = 2'd2;
    localparam logic [1:0] DRV_RIGHT   = 2'd3;

    localparam logic [2:0] REG_CLEAR_MIN = 3'd0;
    localparam logic [2:0] REG_RED_MIN   = 3'd1;
    localparam logic [2:0] REG_GREEN_MIN = 3'd2;
    localparam logic [2:0] REG_BLUE_MIN  = 3'd3;
    localparam logic [2:0] REG_PAUSE_LEN = 3'd4;
    localparam logic [2:0] REG_FWD_DUTY  = 3'd5;
    localparam logic [2:0] REG_LEFT_DUTY = 3'd6;
    localparam logic [2:0] REG_RIGHT_DUTY = 3'd7;

    localparam logic [CNT_W-1:0]   RST_CLEAR_MIN = CNT_W'(80);
    localparam logic [SHARE_W-1:0] RST_RED_MIN   = SHARE_W'(38);
    localparam logic [SHARE_W-1:0] RST_GREEN_MIN = SHARE_W'(34);
    localparam logic [SHARE_W-1:0] RST_BLUE_MIN  = SHARE_W'(30);
    localparam logic [CNT_W-1:0]   RST_PAUSE_LEN = CNT_W'(2000);
    localparam logic [DUTY_W-1:0]  RST_FWD_DUTY  = DUTY_W'(614);
    localparam logic [DUTY_W-1:0]  RST_LEFT_DUTY = DUTY_W'(563);
    localparam logic [DUTY_W-1:0]  RST_RIGHT_DUTY = DUTY_W'(665);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SORT,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic              command;
        logic [7:0]        remote_byte;
        logic              sample_valid;
        logic [CNT_W-1:0]  clear_count;
        logic [CNT_W-1:0]  red_count;
        logic [CNT_W-1:0]  green_count;
        logic [CNT_W-1:0]  blue_count;
        logic [TIME_W-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] motor_duty;
        logic              drive_enable;
        logic              fan_on;
        logic [1:0]        color_class;
        logic [1:0]        override_mode;
    } t_out_item;

endpackage

// ----- src/color_guided_drive_controller_top.sv -----
// Color guided drive controller: command decode, color sort with shared divider, override FSM.
//
//  channel | signals                                   | direction
//  in      | i_in_valid, o_in_ready, i_in_data         | item in
//  out     | o_out_valid, i_out_ready, o_out_data      | result out
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | register write / read
//          | prdata, pready                            |
//
// Command items and samples that skip the sort go from idle straight to the apply step.
// A sorted sample passes through the divide, sort and apply steps: one restoring divider, one quotient
// bit per cycle, runs for the red, green and blue shares in turn.
// Input ready is high only in idle; a waiting result holds the block in its last step.
// Reset is synchronous, active low, and loads the register defaults.
module color_guided_drive_controller_top
    import cgdc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    t_state              r_state, n_state;
    t_in_item            r_item, n_item;
    logic [CNT_W:0]      r_rem, n_rem;
    logic [PCT_W-1:0]    r_quo, n_quo;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [1:0]          r_chan, n_chan;
    logic [PCT_W-1:0]    r_pct [3];
    logic [PCT_W-1:0]    n_pct [3];
    logic [1:0]          r_verdict, n_verdict;

    logic [DUTY_W-1:0]   r_duty, n_duty;
    logic                r_enable, n_enable;
    logic                r_fan, n_fan;
    logic                r_fan_saved, n_fan_saved;
    logic [1:0]          r_drive, n_drive;
    logic [1:0]          r_ovr, n_ovr;
    logic [TIME_W-1:0]   r_pause_start, n_pause_start;
    logic [1:0]          r_class, n_class;

    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [CNT_W-1:0]    r_clear_min;
    logic [SHARE_W-1:0]  r_red_min, r_green_min, r_blue_min;
    logic [CNT_W-1:0]    r_pause_len;
    logic [DUTY_W-1:0]   r_fwd_duty, r_left_duty, r_right_duty;

    logic                cfg_wr;
    logic [2:0]          cfg_idx;
    logic                in_xfer;
    logic                skip_sort;
    logic [CNT_W:0]      div_t;
    logic [CNT_W:0]      div_sub;
    logic                div_ge;
    logic [PCT_W:0]      rp, gp, bp;
    logic [TIME_W-1:0]   elapsed;
    logic                out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;

    assign skip_sort = ~i_in_data.sample_valid | (i_in_data.clear_count < r_clear_min)
                     | (i_in_data.clear_count == '0);

    assign div_t   = {r_rem[CNT_W-1:0], r_quo[PCT_W-1]};
    assign div_ge  = div_t >= {1'b0, r_item.clear_count};
    assign div_sub = div_t - {1'b0, r_item.clear_count};

    assign rp = {1'b0, r_pct[0]};
    assign gp = {1'b0, r_pct[1]};
    assign bp = {1'b0, r_pct[2]};

    assign elapsed = r_item.time_ms - r_pause_start;

    function automatic logic [PCT_W-1:0] scale(input logic [CNT_W-1:0] x);
        return PCT_W'(x) * PCT_SCALE;
    endfunction

    always_comb begin
        unique case (cfg_idx)
            REG_CLEAR_MIN:  prdata = DATA_W'(r_clear_min);
            REG_RED_MIN:    prdata = DATA_W'(r_red_min);
            REG_GREEN_MIN:  prdata = DATA_W'(r_green_min);
            REG_BLUE_MIN:   prdata = DATA_W'(r_blue_min);
            REG_PAUSE_LEN:  prdata = DATA_W'(r_pause_len);
            REG_FWD_DUTY:   prdata = DATA_W'(r_fwd_duty);
            REG_LEFT_DUTY:  prdata = DATA_W'(r_left_duty);
            REG_RIGHT_DUTY: prdata = DATA_W'(r_right_duty);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_min  <= RST_CLEAR_MIN;
            r_red_min    <= RST_RED_MIN;
            r_green_min  <= RST_GREEN_MIN;
            r_blue_min   <= RST_BLUE_MIN;
            r_pause_len  <= RST_PAUSE_LEN;
            r_fwd_duty   <= RST_FWD_DUTY;
            r_left_duty  <= RST_LEFT_DUTY;
            r_right_duty <= RST_RIGHT_DUTY;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CLEAR_MIN:  r_clear_min  <= pwdata[CNT_W-1:0];
                REG_RED_MIN:    r_red_min    <= pwdata[SHARE_W-1:0];
                REG_GREEN_MIN:  r_green_min  <= pwdata[SHARE_W-1:0];
                REG_BLUE_MIN:   r_blue_min   <= pwdata[SHARE_W-1:0];
                REG_PAUSE_LEN:  r_pause_len  <= pwdata[CNT_W-1:0];
                REG_FWD_DUTY:   r_fwd_duty   <= pwdata[DUTY_W-1:0];
                REG_LEFT_DUTY:  r_left_duty  <= pwdata[DUTY_W-1:0];
                REG_RIGHT_DUTY: r_right_duty <= pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_cnt         = r_cnt;
        n_chan        = r_chan;
        n_pct         = r_pct;
        n_verdict     = r_verdict;
        n_duty        = r_duty;
        n_enable      = r_enable;
        n_fan         = r_fan;
        n_fan_saved   = r_fan_saved;
        n_drive       = r_drive;
        n_ovr         = r_ovr;
        n_pause_start = r_pause_start;
        n_class       = r_class;
        n_out_valid   = r_out_valid & ~i_out_ready;
        n_out         = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item    = i_in_data;
                    n_verdict = CLS_UNKNOWN;
                    n_rem     = '0;
                    n_quo     = scale(i_in_data.red_count);
                    n_cnt     = '0;
                    n_chan    = 2'd0;
                    if (!i_in_data.command || skip_sort) begin
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_sub : div_t;
                n_quo = {r_quo[PCT_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(PCT_W - 1)) begin
                    n_pct[r_chan] = {r_quo[PCT_W-2:0], div_ge};
                    n_rem  = '0;
                    n_cnt  = '0;
                    n_chan = r_chan + 1'b1;
                    n_quo  = (r_chan == 2'd0) ? scale(r_item.green_count)
                                              : scale(r_item.blue_count);
                    if (r_chan == 2'd2) begin
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (rp > gp + PCT_MARGIN && rp > bp + PCT_MARGIN
                        && rp >= (PCT_W + 1)'(r_red_min)) begin
                    n_verdict = CLS_RED;
                end else if (gp > rp + PCT_MARGIN && gp > bp + PCT_MARGIN
                        && gp >= (PCT_W + 1)'(r_green_min)) begin
                    n_verdict = CLS_GREEN;
                end else if (bp > rp + PCT_MARGIN && bp > gp + PCT_MARGIN
                        && bp >= (PCT_W + 1)'(r_blue_min)) begin
                    n_verdict = CLS_BLUE;
                end else begin
                    n_verdict = CLS_UNKNOWN;
                end
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    if (!r_item.command) begin
                        case (r_item.remote_byte)
                            CMD_STOP: begin
                                n_enable = 1'b0;
                                n_fan    = 1'b0;
                                n_drive  = DRV_NONE;
                            end
                            CMD_ENABLE: begin
                                n_enable = 1'b0;
                                n_fan    = 1'b1;
                                n_drive  = DRV_NONE;
                            end
                            CMD_FORWARD: begin
                                n_enable = 1'b1;
                                n_drive  = DRV_FORWARD;
                                n_duty   = r_fwd_duty;
                            end
                            CMD_LEFT: begin
                                n_enable = 1'b1;
                                n_drive  = DRV_LEFT;
                                n_duty   = r_left_duty;
                            end
                            CMD_RIGHT: begin
                                n_enable = 1'b1;
                                n_drive  = DRV_RIGHT;
                                n_duty   = r_right_duty;
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        n_class = r_verdict;
                        case (r_verdict)
                            CLS_RED: begin
                                if (r_ovr == OVR_PAUSE && r_fan_saved) begin
                                    n_fan = 1'b1;
                                end
                                n_ovr  = OVR_RED;
                                n_duty = r_right_duty;
                            end
                            CLS_GREEN: begin
                                if (r_ovr == OVR_TURN) begin
                                    n_duty = r_right_duty;
                                end else if (r_ovr == OVR_PAUSE) begin
                                    if (elapsed >= TIME_W'(r_pause_len)) begin
                                        if (r_fan_saved) begin
                                            n_fan = 1'b1;
                                        end
                                        n_ovr  = OVR_TURN;
                                        n_duty = r_right_duty;
                                    end
                                end else begin
                                    // entering the pause: it starts at this sample's time stamp
                                    n_pause_start = r_item.time_ms;
                                    n_fan_saved   = r_fan;
                                    if (r_pause_len == '0) begin
                                        n_fan  = r_fan;
                                        n_ovr  = OVR_TURN;
                                        n_duty = r_right_duty;
                                    end else begin
                                        n_fan = 1'b0;
                                        n_ovr = OVR_PAUSE;
                                    end
                                end
                            end
                            CLS_BLUE: begin
                            end
                            default: begin
                                if (r_ovr != OVR_NONE) begin
                                    if (r_ovr == OVR_PAUSE && r_fan_saved) begin
                                        n_fan = 1'b1;
                                    end
                                    n_ovr = OVR_NONE;
                                    case (r_drive)
                                        DRV_FORWARD: n_duty = r_fwd_duty;
                                        DRV_LEFT:    n_duty = r_left_duty;
                                        DRV_RIGHT:   n_duty = r_right_duty;
                                        default:     n_duty = r_duty;
                                    endcase
                                end
                            end
                        endcase
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
                n_out.motor_duty    = n_duty;
                n_out.drive_enable  = n_enable;
                n_out.fan_on        = n_fan;
                n_out.color_class   = n_class;
                n_out.override_mode = n_ovr;
                if (!out_free) begin
                    n_out = r_out;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_duty        <= RST_FWD_DUTY;
            r_enable      <= 1'b0;
            r_fan         <= 1'b1;
            r_fan_saved   <= 1'b1;
            r_drive       <= DRV_NONE;
            r_ovr         <= OVR_NONE;
            r_pause_start <= '0;
            r_class       <= CLS_UNKNOWN;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
            r_chan        <= 2'd0;
            r_verdict     <= CLS_UNKNOWN;
        end else begin
            r_state       <= n_state;
            r_duty        <= n_duty;
            r_enable      <= n_enable;
            r_fan         <= n_fan;
            r_fan_saved   <= n_fan_saved;
            r_drive       <= n_drive;
            r_ovr         <= n_ovr;
            r_pause_start <= n_pause_start;
            r_class       <= n_class;
            r_out_valid   <= n_out_valid;
            r_cnt         <= n_cnt;
            r_chan        <= n_chan;
            r_verdict     <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_pct  <= n_pct;
        r_out  <= n_out;
    end

endmodule

// ----- test/color_guided_drive_controller_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for the color guided drive controller: directed table, random items, result check.
module color_guided_drive_controller_top_test;
    import cgdc_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int MAX_WAIT        = 13;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int SHARE_SCALE     = 100;
    localparam int SHARE_MARGIN    = 8;
    localparam bit PRED            = 1'b0;
    localparam bit TYPED           = 1'b1;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // register copy
    logic [CNT_W-1:0]   cfg_clear_min;
    logic [SHARE_W-1:0] cfg_red_min;
    logic [SHARE_W-1:0] cfg_green_min;
    logic [SHARE_W-1:0] cfg_blue_min;
    logic [CNT_W-1:0]   cfg_pause_len;
    logic [DUTY_W-1:0]  cfg_fwd_duty;
    logic [DUTY_W-1:0]  cfg_left_duty;
    logic [DUTY_W-1:0]  cfg_right_duty;

    // controller state copy
    logic [DUTY_W-1:0] duty_q;
    logic              enable_q;
    logic              fan_q;
    logic              fan_kept_q;
    logic [1:0]        drive_kept_q;
    logic [1:0]        mode_q;
    logic [TIME_W-1:0] pause_t0_q;
    logic [1:0]        class_q;

    t_out_item         pending_outputs[$];
    logic [2:0]        reg_list [8] = '{REG_CLEAR_MIN, REG_RED_MIN, REG_GREEN_MIN, REG_BLUE_MIN,
                                        REG_PAUSE_LEN, REG_FWD_DUTY, REG_LEFT_DUTY,
                                        REG_RIGHT_DUTY};
    logic [7:0]        cmd_codes [5] = '{CMD_STOP, CMD_ENABLE, CMD_FORWARD, CMD_LEFT, CMD_RIGHT};
    logic [TIME_W-1:0] stamp_now = '0;
    logic [1:0]        cur_target = CLS_UNKNOWN;
    bit                no_idle = 1'b0;
    int                items_sent = 0;
    int                results_seen = 0;
    int                failures = 0;
    int                green_turns = 0;
    int                verdict_hits [4] = '{0, 0, 0, 0};

    color_guided_drive_controller_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_out_item res(input logic [DUTY_W-1:0] duty, input logic en,
                                      input logic fan, input logic [1:0] cls,
                                      input logic [1:0] mode);
        t_out_item r;
        r.motor_duty    = duty;
        r.drive_enable  = en;
        r.fan_on        = fan;
        r.color_class   = cls;
        r.override_mode = mode;
        return r;
    endfunction

    function automatic t_row cmd_row(input logic [7:0] b, input bit fill, input bit typed,
                                     input t_out_item want);
        t_row rw;
        rw.item = '0;
        if (fill) begin
            rw.item = '1;
        end
        rw.item.command     = 1'b0;
        rw.item.remote_byte = b;
        rw.typed            = typed;
        rw.want             = want;
        return rw;
    endfunction

    function automatic t_row smp_row(input logic valid, input logic [CNT_W-1:0] c, r, g, b,
                                     input logic [TIME_W-1:0] t, input bit typed,
                                     input t_out_item want);
        t_row rw;
        rw.item              = '0;
        rw.item.command      = 1'b1;
        rw.item.remote_byte  = CMD_RIGHT;
        rw.item.sample_valid = valid;
        rw.item.clear_count  = c;
        rw.item.red_count    = r;
        rw.item.green_count  = g;
        rw.item.blue_count   = b;
        rw.item.time_ms      = t;
        rw.typed             = typed;
        rw.want              = want;
        return rw;
    endfunction

    function automatic void cfg_store(input logic [2:0] idx, input logic [DATA_W-1:0] v);
        case (idx)
            REG_CLEAR_MIN:  cfg_clear_min  = v[CNT_W-1:0];
            REG_RED_MIN:    cfg_red_min    = v[SHARE_W-1:0];
            REG_GREEN_MIN:  cfg_green_min  = v[SHARE_W-1:0];
            REG_BLUE_MIN:   cfg_blue_min   = v[SHARE_W-1:0];
            REG_PAUSE_LEN:  cfg_pause_len  = v[CNT_W-1:0];
            REG_FWD_DUTY:   cfg_fwd_duty   = v[DUTY_W-1:0];
            REG_LEFT_DUTY:  cfg_left_duty  = v[DUTY_W-1:0];
            REG_RIGHT_DUTY: cfg_right_duty = v[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] cfg_value(input logic [2:0] idx);
        case (idx)
            REG_CLEAR_MIN:  return DATA_W'(cfg_clear_min);
            REG_RED_MIN:    return DATA_W'(cfg_red_min);
            REG_GREEN_MIN:  return DATA_W'(cfg_green_min);
            REG_BLUE_MIN:   return DATA_W'(cfg_blue_min);
            REG_PAUSE_LEN:  return DATA_W'(cfg_pause_len);
            REG_FWD_DUTY:   return DATA_W'(cfg_fwd_duty);
            REG_LEFT_DUTY:  return DATA_W'(cfg_left_duty);
            default:        return DATA_W'(cfg_right_duty);
        endcase
    endfunction

    function automatic logic [1:0] sort_color(input logic [CNT_W-1:0] c, r, g, b);
        int unsigned rp;
        int unsigned gp;
        int unsigned bp;
        if (c < cfg_clear_min || c == '0) begin
            return CLS_UNKNOWN;
        end
        rp = (32'(r) * SHARE_SCALE) / 32'(c);
        gp = (32'(g) * SHARE_SCALE) / 32'(c);
        bp = (32'(b) * SHARE_SCALE) / 32'(c);
        if (rp > gp + SHARE_MARGIN && rp > bp + SHARE_MARGIN && rp >= cfg_red_min) begin
            return CLS_RED;
        end
        if (gp > rp + SHARE_MARGIN && gp > bp + SHARE_MARGIN && gp >= cfg_green_min) begin
            return CLS_GREEN;
        end
        if (bp > rp + SHARE_MARGIN && bp > gp + SHARE_MARGIN && bp >= cfg_blue_min) begin
            return CLS_BLUE;
        end
        return CLS_UNKNOWN;
    endfunction

    function automatic void steer(input logic [1:0] d);
        case (d)
            DRV_FORWARD: duty_q = cfg_fwd_duty;
            DRV_LEFT:    duty_q = cfg_left_duty;
            DRV_RIGHT:   duty_q = cfg_right_duty;
            default: ;
        endcase
    endfunction

    function automatic void apply_verdict(input logic [1:0] v, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        bit                hold;
        hold = 1'b0;
        case (v)
            CLS_RED: begin
                if (mode_q == OVR_PAUSE && fan_kept_q) begin
                    fan_q = 1'b1;
                end
                mode_q = OVR_RED;
                steer(DRV_RIGHT);
            end
            CLS_GREEN: begin
                if (mode_q != OVR_PAUSE && mode_q != OVR_TURN) begin
                    mode_q     = OVR_PAUSE;
                    fan_kept_q = fan_q;
                    fan_q      = 1'b0;
                    pause_t0_q = now;
                end
                if (mode_q == OVR_PAUSE) begin
                    elapsed = now - pause_t0_q;
                    if (elapsed < TIME_W'(cfg_pause_len)) begin
                        hold = 1'b1;
                    end else begin
                        if (fan_kept_q) begin
                            fan_q = 1'b1;
                        end
                        mode_q = OVR_TURN;
                        green_turns++;
                    end
                end
                if (!hold) begin
                    steer(DRV_RIGHT);
                end
            end
            CLS_BLUE: ;
            default: begin
                if (mode_q != OVR_NONE) begin
                    if (mode_q == OVR_PAUSE && fan_kept_q) begin
                        fan_q = 1'b1;
                    end
                    mode_q = OVR_NONE;
                    steer(drive_kept_q);
                end
            end
        endcase
    endfunction

    function automatic t_out_item drive_outputs_after(input t_in_item it);
        logic [1:0] v;
        if (!it.command) begin
            case (it.remote_byte)
                CMD_STOP: begin
                    enable_q     = 1'b0;
                    fan_q        = 1'b0;
                    drive_kept_q = DRV_NONE;
                end
                CMD_ENABLE: begin
                    enable_q     = 1'b0;
                    fan_q        = 1'b1;
                    drive_kept_q = DRV_NONE;
                end
                CMD_FORWARD: begin
                    enable_q     = 1'b1;
                    drive_kept_q = DRV_FORWARD;
                    steer(DRV_FORWARD);
                end
                CMD_LEFT: begin
                    enable_q     = 1'b1;
                    drive_kept_q = DRV_LEFT;
                    steer(DRV_LEFT);
                end
                CMD_RIGHT: begin
                    enable_q     = 1'b1;
                    drive_kept_q = DRV_RIGHT;
                    steer(DRV_RIGHT);
                end
                default: ;
            endcase
        end else begin
            v = CLS_UNKNOWN;
            if (it.sample_valid) begin
                v = sort_color(it.clear_count, it.red_count, it.green_count, it.blue_count);
            end
            class_q = v;
            verdict_hits[v]++;
            apply_verdict(v, it.time_ms);
        end
        return res(duty_q, enable_q, fan_q, class_q, mode_q);
    endfunction

    function automatic logic [CNT_W-1:0] scaled(input int unsigned c, input bit dominant,
                                                input int unsigned top);
        if (dominant) begin
            return CNT_W'(c * $urandom_range(35, 100) / SHARE_SCALE);
        end
        return CNT_W'(c * $urandom_range(0, top) / SHARE_SCALE);
    endfunction

    function automatic t_in_item gen_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned c;
        int unsigned lo;
        int unsigned hi;
        it   = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            it.command = 1'b0;
            if ($urandom_range(0, 9) < 7) begin
                it.remote_byte = cmd_codes[$urandom_range(0, 4)];
            end
        end else begin
            it.command      = 1'b1;
            it.sample_valid = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 19) == 0) begin
                stamp_now = $urandom;
            end else begin
                stamp_now = stamp_now + $urandom_range(0, cfg_pause_len / 3 + 40);
            end
            it.time_ms = stamp_now;
            if ($urandom_range(0, 99) < 20) begin
                cur_target = 2'($urandom_range(0, 3));
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                c = 0;
            end else if (pick < 10) begin
                c = 65535;
            end else if (pick < 20) begin
                c = $urandom_range(0, 65535);
            end else begin
                lo = cfg_clear_min / 2;
                hi = cfg_clear_min + 3000;
                if (hi > 65535) begin
                    hi = 65535;
                end
                c = $urandom_range(lo, hi);
            end
            it.clear_count = CNT_W'(c);
            // one sample in ten keeps its raw random counts
            if ($urandom_range(0, 9) != 0) begin
                hi = (cur_target == CLS_UNKNOWN) ? 100 : 30;
                it.red_count   = scaled(c, cur_target == CLS_RED, hi);
                it.green_count = scaled(c, cur_target == CLS_GREEN, hi);
                it.blue_count  = scaled(c, cur_target == CLS_BLUE, hi);
            end
        end
        return it;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg_store(idx, v);
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        v = prdata;
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_out);
        int        gap;
        t_out_item pred;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = drive_outputs_after(it);
        pending_outputs.push_back(typed ? typed_out : pred);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    initial begin : result_check
        t_out_item got;
        t_out_item want;
        int        stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got = o_out_data;
            results_seen++;
            if (pending_outputs.size() == 0) begin
                note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_outputs.pop_front();
                if (got.motor_duty !== want.motor_duty || got.drive_enable !== want.drive_enable
                        || got.fan_on !== want.fan_on || got.color_class !== want.color_class
                        || got.override_mode !== want.override_mode) begin
                    note_failure($sformatf(
                        "result %0d exp/act: duty %0d/%0d en %0b/%0b fan %0b/%0b cls %0d/%0d ovr %0d/%0d",
                        results_seen, want.motor_duty, got.motor_duty, want.drive_enable,
                        got.drive_enable, want.fan_on, got.fan_on, want.color_class,
                        got.color_class, want.override_mode, got.override_mode));
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (psel && penable && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("color_guided_drive_controller_top regression: fail");
        $finish;
    end

    initial begin : main
        t_row              rows[$];
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] v;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        cfg_clear_min  = RST_CLEAR_MIN;
        cfg_red_min    = RST_RED_MIN;
        cfg_green_min  = RST_GREEN_MIN;
        cfg_blue_min   = RST_BLUE_MIN;
        cfg_pause_len  = RST_PAUSE_LEN;
        cfg_fwd_duty   = RST_FWD_DUTY;
        cfg_left_duty  = RST_LEFT_DUTY;
        cfg_right_duty = RST_RIGHT_DUTY;
        duty_q         = RST_FWD_DUTY;
        enable_q       = 1'b0;
        fan_q          = 1'b1;
        fan_kept_q     = 1'b1;
        drive_kept_q   = DRV_NONE;
        mode_q         = OVR_NONE;
        pause_t0_q     = '0;
        class_q        = CLS_UNKNOWN;

        // unknown bytes after reset, one with every ignored sample bit set
        rows.push_back(cmd_row(8'h00, 1'b0, TYPED,
                               res(13'd614, 1'b0, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(8'hff, 1'b1, TYPED,
                               res(13'd614, 1'b0, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_FORWARD, 1'b0, TYPED,
                               res(13'd614, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_LEFT, 1'b0, TYPED,
                               res(13'd563, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_RIGHT, 1'b0, TYPED,
                               res(13'd665, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_STOP, 1'b0, TYPED,
                               res(13'd665, 1'b0, 1'b0, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_ENABLE, 1'b1, TYPED,
                               res(13'd665, 1'b0, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(cmd_row(CMD_FORWARD, 1'b0, TYPED,
                               res(13'd614, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        // invalid sample, then zero clear count
        rows.push_back(smp_row(1'b0, 16'hffff, 16'hffff, 16'h0, 16'h0, 32'hffff_ffff, TYPED,
                               res(13'd614, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(smp_row(1'b1, 16'd0, 16'hffff, 16'd0, 16'd0, 32'd0, TYPED,
                               res(13'd614, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd600, 16'd200, 16'd100, 32'd0, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd10, 16'd6, 16'd2, 16'd1, 32'd0, PRED, '0));
        // green pause, one ms short, then turn
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd100, 16'd600, 16'd100, 32'd100, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd100, 16'd600, 16'd100, 32'd2099, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd100, 16'd600, 16'd100, 32'd2100, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd100, 16'd100, 16'd600, 32'd0, PRED, '0));
        rows.push_back(smp_row(1'b0, 16'd1000, 16'd100, 16'd100, 16'd600, 32'd0, PRED, '0));
        // pause across the stamp wrap
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd0, 16'd900, 16'd0, 32'hffff_ff00, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd0, 16'd900, 16'd0, 32'h0000_0700, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd900, 16'd0, 16'd0, 32'd0, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd0, 16'd900, 16'd0, 32'd5, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'd1000, 16'd900, 16'd0, 16'd0, 32'd6, PRED, '0));
        rows.push_back(smp_row(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'd0, TYPED,
                               res(13'd614, 1'b1, 1'b1, CLS_UNKNOWN, OVR_NONE)));
        rows.push_back(smp_row(1'b1, 16'hffff, 16'hffff, 16'h0, 16'h0, 32'd0, TYPED,
                               res(13'd665, 1'b1, 1'b1, CLS_RED, OVR_RED)));
        rows.push_back(cmd_row(CMD_STOP, 1'b0, PRED, '0));
        rows.push_back(smp_row(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, PRED, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                repeat (4) @(posedge i_clk);
                foreach (reg_list[k]) begin
                    case (p)
                        1: v = '0;
                        2: v = '1;
                        default: begin
                            // upper bits are junk the register must drop
                            v = $urandom & 32'hffff_0000;
                            case (reg_list[k])
                                REG_CLEAR_MIN: v[15:0] = 16'($urandom_range(0, 200));
                                REG_RED_MIN, REG_GREEN_MIN, REG_BLUE_MIN:
                                    v[15:0] = 16'($urandom_range(0, 60));
                                REG_PAUSE_LEN: v[15:0] = 16'($urandom_range(0, 5000));
                                default: v[15:0] = 16'($urandom_range(0, 8191));
                            endcase
                        end
                    endcase
                    apb_write(reg_list[k], v);
                end
            end
            foreach (reg_list[k]) begin
                apb_read(reg_list[k], rd);
                if (rd !== cfg_value(reg_list[k])) begin
                    note_failure($sformatf("register %0d read exp/act: %0h/%0h", reg_list[k],
                                           cfg_value(reg_list[k]), rd));
                end
            end
            psel    <= 1'b0;
            penable <= 1'b0;

            if (p == 0) begin
                foreach (rows[k]) begin
                    send_item(rows[k].item, rows[k].typed, rows[k].want);
                end
            end
            stamp_now = (p == 4) ? 32'hffff_f000 : $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 64 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 299) == 0) begin
                    wait_drained();
                end
                send_item(gen_item(), PRED, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_outputs.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_outputs.size()));
        end

        $display("%0d items over %0d register settings, %0d results checked, %0d failures",
                 items_sent, NUM_PHASES, results_seen, failures);
        $display("verdicts unknown/red/green/blue %0d/%0d/%0d/%0d, green turns %0d",
                 verdict_hits[CLS_UNKNOWN], verdict_hits[CLS_RED], verdict_hits[CLS_GREEN],
                 verdict_hits[CLS_BLUE], green_turns);
        if (failures == 0) begin
            $display("color_guided_drive_controller_top regression: pass");
        end else begin
            $display("color_guided_drive_controller_top regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/cgdc_pkg.sv
src/color_guided_drive_controller_top.sv
test/color_guided_drive_controller_top_test.sv
